@@ design/scpd_pkg.sv @@
`default_nettype none

package scpd_pkg;

	localparam int FRAME_BYTES = 8;
	localparam int HELD_BYTES  = 5;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] pos_t;
	typedef logic [1:0] cfg_idx_t;

	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	localparam cfg_idx_t CFG_SYNC_FIRST  = 2'd0;
	localparam cfg_idx_t CFG_SYNC_SECOND = 2'd1;
	localparam cfg_idx_t CFG_TYPE_LIMIT  = 2'd2;

	localparam pos_t POS_SYNC_FIRST  = 3'd0;
	localparam pos_t POS_SYNC_SECOND = 3'd1;
	localparam pos_t POS_TYPE        = 3'd2;
	localparam pos_t POS_CHECKSUM    = 3'(FRAME_BYTES - 1);

	localparam byte_t    SYNC_FIRST_RESET  = 8'd170;
	localparam byte_t    SYNC_SECOND_RESET = 8'd85;
	localparam logic [8:0] TYPE_LIMIT_RESET = 9'd256;

	typedef struct packed {
		byte_t      sync_first;
		byte_t      sync_second;
		logic [8:0] type_limit;
	} cfg_t;

	typedef struct packed {
		logic  fetched;
		byte_t frame_type;
		byte_t payload_0;
		byte_t payload_1;
		byte_t payload_2;
		byte_t payload_3;
		logic  holding_full;
	} result_t;

endpackage

`default_nettype wire

@@ design/sync_checksum_packet_deframer_core.sv @@
// Sync-word packet deframer with an 8-byte frame and an additive checksum.
// The input channel (in_valid, in_stall, operation, rx_byte) carries one
// transaction per operation: operation 0 delivers rx_byte to the frame
// assembler, operation 1 fetches the frame waiting in the holding slot.
// Every input transaction yields exactly one output transaction on
// (out_valid, out_stall, fetched, frame_type, payload_0..3, holding_full).
// The configuration port (cfg_we, cfg_index, cfg_data) writes the sync bytes
// and the type limit; write it only while no transaction is in flight.
// An input transaction passes an input register and then the output
// register, which presents its result. One transaction is accepted
// every cycle unless in_stall is high; the deframer state is updated
// by combinational logic as each transaction leaves the input register.
// Reset clears both pipeline stages, the byte position and the ready flag,
// and loads the default sync bytes and type limit. When the receiver stalls,
// the output register holds its result, the input register fills, and
// in_stall rises once both are occupied.
`default_nettype none

module sync_checksum_packet_deframer_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire logic              operation,
	input  wire scpd_pkg::byte_t   rx_byte,
	output      logic              out_valid,
	input  wire logic              out_stall,
	output      logic              fetched,
	output      scpd_pkg::byte_t   frame_type,
	output      scpd_pkg::byte_t   payload_0,
	output      scpd_pkg::byte_t   payload_1,
	output      scpd_pkg::byte_t   payload_2,
	output      scpd_pkg::byte_t   payload_3,
	output      logic              holding_full,
	input  wire logic              cfg_we,
	input  wire scpd_pkg::cfg_idx_t cfg_index,
	input  wire logic [8:0]        cfg_data
);
	import scpd_pkg::*;

	logic    valid_s1;
	logic    operation_s1;
	byte_t   rx_byte_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result;
	cfg_t    cfg;
	logic    s2_ready;
	logic    advance;
	logic    in_accept;

	assign s2_ready  = !valid_s2 || !out_stall;
	assign advance   = valid_s1 && s2_ready;
	assign in_stall  = valid_s1 && !s2_ready;
	assign in_accept = in_valid && !in_stall;

	scpd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	scpd_deframer u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.operation (operation_s1),
		.rx_byte   (rx_byte_s1),
		.cfg       (cfg),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			operation_s1 <= operation;
			rx_byte_s1   <= rx_byte;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid    = valid_s2;
	assign fetched      = result_s2.fetched;
	assign frame_type   = result_s2.frame_type;
	assign payload_0    = result_s2.payload_0;
	assign payload_1    = result_s2.payload_1;
	assign payload_2    = result_s2.payload_2;
	assign payload_3    = result_s2.payload_3;
	assign holding_full = result_s2.holding_full;

endmodule

`default_nettype wire

@@ design/scpd_cfg_regs.sv @@
`default_nettype none

module scpd_cfg_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire scpd_pkg::cfg_idx_t cfg_index,
	input  wire logic [8:0]        cfg_data,
	output      scpd_pkg::cfg_t    cfg
);
	import scpd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= SYNC_FIRST_RESET;
			cfg_q.sync_second <= SYNC_SECOND_RESET;
			cfg_q.type_limit  <= TYPE_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SYNC_FIRST: begin
					cfg_q.sync_first <= cfg_data[7:0];
				end
				CFG_SYNC_SECOND: begin
					cfg_q.sync_second <= cfg_data[7:0];
				end
				CFG_TYPE_LIMIT: begin
					cfg_q.type_limit <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ design/scpd_deframer.sv @@
`default_nettype none

module scpd_deframer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic             operation,
	input  wire scpd_pkg::byte_t  rx_byte,
	input  wire scpd_pkg::cfg_t   cfg,
	output      scpd_pkg::result_t result
);
	import scpd_pkg::*;

	pos_t  pos_q;
	pos_t  pos_d;
	logic  waiting_q;
	logic  waiting_d;
	logic  buf_we;
	logic  held_load;
	logic  ok;
	byte_t sum;
	byte_t buf_q [0:FRAME_BYTES-2];
	byte_t held_q [0:HELD_BYTES-1];

	assign sum = 8'(buf_q[3] + buf_q[4] + buf_q[5] + buf_q[6]);

	always_comb begin
		pos_d     = pos_q;
		waiting_d = waiting_q;
		buf_we    = 1'b0;
		held_load = 1'b0;
		ok        = 1'b1;
		result    = '0;
		if (operation == OP_FETCH) begin
			if (waiting_q) begin
				result.fetched    = 1'b1;
				result.frame_type = held_q[0];
				result.payload_0  = held_q[1];
				result.payload_1  = held_q[2];
				result.payload_2  = held_q[3];
				result.payload_3  = held_q[4];
				waiting_d         = 1'b0;
			end
		end else if (pos_q == POS_CHECKSUM) begin
			if (sum == rx_byte && !waiting_q) begin
				held_load = 1'b1;
				waiting_d = 1'b1;
			end
			pos_d = POS_SYNC_FIRST;
		end else begin
			case (pos_q)
				POS_SYNC_FIRST: begin
					ok = (rx_byte == cfg.sync_first);
				end
				POS_SYNC_SECOND: begin
					ok = (rx_byte == cfg.sync_second);
				end
				POS_TYPE: begin
					ok = ({1'b0, rx_byte} < cfg.type_limit);
				end
				default: begin
					ok = 1'b1;
				end
			endcase
			if (ok) begin
				buf_we = 1'b1;
				pos_d  = 3'(pos_q + 3'd1);
			end else begin
				pos_d = POS_SYNC_FIRST;
			end
		end
		result.holding_full = waiting_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_SYNC_FIRST;
			waiting_q <= 1'b0;
		end else if (advance) begin
			pos_q     <= pos_d;
			waiting_q <= waiting_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && buf_we) begin
			buf_q[pos_q] <= rx_byte;
		end
		if (advance && held_load) begin
			for (int i = 0; i < HELD_BYTES; i++) begin
				held_q[i] <= buf_q[i + 2];
			end
		end
	end

`ifndef SYNTH
	a_fetch_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && operation == OP_FETCH && waiting_q |=> !waiting_q)
		else $error("A fetch of a held frame did not clear the ready flag.");

	a_good_frame_held: assert property (@(posedge clk) disable iff (!arst_n)
		advance && operation == OP_BYTE && pos_q == POS_CHECKSUM && !waiting_q
		&& sum == rx_byte |=> waiting_q && pos_q == POS_SYNC_FIRST)
		else $error("A frame with a good checksum was not taken into the slot.");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(pos_q) && $stable(waiting_q))
		else $error("Deframer state changed without a transaction.");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		advance && operation == OP_BYTE && waiting_q |=> waiting_q)
		else $error("A received byte cleared the ready flag.");
`endif

endmodule

`default_nettype wire
